@@ src/h2r_pkg.sv @@
package h2r_pkg;

  // input hue word
  localparam int HUE_WIDTH = 14;

  // defaults for the top level parameters
  localparam int HUE_FRACTION_BITS_DEF = 4;
  localparam int COLOR_BITS_DEF = 8;

  // configuration register map
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_SATURATION = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_BRIGHTNESS = 1'b1;

  // 60 degree slice of the color wheel
  typedef enum logic [2:0] {
    SXT_RED_YELLOW   = 3'd0,
    SXT_YELLOW_GREEN = 3'd1,
    SXT_GREEN_CYAN   = 3'd2,
    SXT_CYAN_BLUE    = 3'd3,
    SXT_BLUE_MAGENTA = 3'd4,
    SXT_MAGENTA_RED  = 3'd5
  } sextant_t;

endpackage

@@ src/h2r_hue_if.sv @@
interface h2r_hue_if import h2r_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [HUE_WIDTH-1:0] hue;

  modport source (output valid, output hue, input ready);
  modport sink (input valid, input hue, output ready);
endinterface

@@ src/h2r_rgb_if.sv @@
interface h2r_rgb_if import h2r_pkg::*; #(
  parameter int COLOR_BITS = COLOR_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic [COLOR_BITS-1:0] red;
  logic [COLOR_BITS-1:0] green;
  logic [COLOR_BITS-1:0] blue;
  logic                  hue_out_of_range;

  modport source (output valid, output red, output green, output blue,
                  output hue_out_of_range, input ready);
  modport sink (input valid, input red, input green, input blue,
                input hue_out_of_range, output ready);
endinterface

@@ src/hsv_to_rgb_pixel.sv @@
// hsv to rgb pixel converter: takes one signed hue per transfer, in units of
// 2^-HUE_FRACTION_BITS degree, and returns a red, green, blue triple of
// COLOR_BITS each, with saturation and brightness taken from two
// configuration registers (index 0 saturation, reset 0.80 of full scale;
// index 1 brightness, reset full scale). every channel is the exact rational
// result truncated toward zero. a hue below 0 or at or above 360 degrees
// gives all three channels at the offset level brightness*(1-saturation)
// and raises hue_out_of_range. the datapath is a five stage pipeline: one
// hue enters every clock while the output is not stalled, so the sustained
// rate is one transfer per cycle; the stages are range check and sextant,
// saturation term, brightness scaling, reciprocal quotient estimate, then
// remainder check and channel steering into the output register. a stall on
// the output holds the whole pipeline in place. write the registers only
// while no transfer is in flight.
module hsv_to_rgb_pixel import h2r_pkg::*; #(
  parameter int HUE_FRACTION_BITS = HUE_FRACTION_BITS_DEF,
  parameter int COLOR_BITS = COLOR_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [COLOR_BITS-1:0]  cfg_data,
  h2r_hue_if.sink                pixel_in,
  h2r_rgb_if.source              pixel_out
);

  // full scale level and sextant width in hue units
  localparam int FULL = (1 << COLOR_BITS) - 1;
  localparam int SEXT = 60 << HUE_FRACTION_BITS;
  localparam int HUE_LIMIT = 6 * SEXT;
  localparam int SAT_RESET = (FULL * 4 + 2) / 5;
  localparam int DW = $clog2(SEXT + 1);
  // full * sextant width, the common denominator
  localparam longint unsigned DEN = longint'(FULL) * longint'(SEXT);
  localparam int TW = $clog2(DEN + 1);
  localparam int PW = COLOR_BITS + TW;
  // sextant width is 15 * 2^(fraction bits + 2): the power of two goes first
  localparam int SHIFT = HUE_FRACTION_BITS + 2;
  localparam int XW = PW - SHIFT;
  localparam int KDIV = FULL * 15;
  localparam longint unsigned RECIP = (64'd1 << XW) / longint'(KDIV);
  localparam int RW = $clog2(RECIP + 1);

  // configuration registers
  logic [COLOR_BITS-1:0] saturation;
  logic [COLOR_BITS-1:0] brightness;

  always_ff @(posedge clk) begin
    if (rst) begin
      saturation <= COLOR_BITS'(SAT_RESET);
      brightness <= COLOR_BITS'(FULL);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SATURATION: saturation <= cfg_data;
        REG_BRIGHTNESS: brightness <= cfg_data;
        default: ;
      endcase
    end
  end

  // whole pipeline moves when the output slot is free or being taken
  logic adv;
  logic [4:0] vld;

  assign adv = !vld[4] || pixel_out.ready;
  assign pixel_in.ready = adv;
  assign pixel_out.valid = vld[4];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[3:0], pixel_in.valid};
    end
  end

  // stage 1: range check, sextant and distance from the nearest primary
  logic signed [31:0] hue_wide;
  sextant_t           sx_c;
  logic [31:0]        base_c;
  logic [31:0]        rem_c;
  logic [DW-1:0]      frac_c;
  logic               oor_c;

  always_comb begin
    hue_wide = 32'(pixel_in.hue);
    oor_c = (hue_wide < 0) || (hue_wide >= HUE_LIMIT);
    if (hue_wide >= 5 * SEXT) begin
      sx_c = SXT_MAGENTA_RED;
      base_c = 32'(5 * SEXT);
    end else if (hue_wide >= 4 * SEXT) begin
      sx_c = SXT_BLUE_MAGENTA;
      base_c = 32'(4 * SEXT);
    end else if (hue_wide >= 3 * SEXT) begin
      sx_c = SXT_CYAN_BLUE;
      base_c = 32'(3 * SEXT);
    end else if (hue_wide >= 2 * SEXT) begin
      sx_c = SXT_GREEN_CYAN;
      base_c = 32'(2 * SEXT);
    end else if (hue_wide >= SEXT) begin
      sx_c = SXT_YELLOW_GREEN;
      base_c = 32'(SEXT);
    end else begin
      sx_c = SXT_RED_YELLOW;
      base_c = '0;
    end
    rem_c = 32'(hue_wide) - base_c;
    // odd sextants fall toward the next primary
    if (sx_c[0]) begin
      frac_c = DW'(SEXT) - DW'(rem_c);
    end else begin
      frac_c = DW'(rem_c);
    end
  end

  sextant_t      sx1;
  logic [DW-1:0] frac1;
  logic          oor1;

  always_ff @(posedge clk) begin
    if (adv) begin
      sx1 <= sx_c;
      frac1 <= frac_c;
      oor1 <= oor_c;
    end
  end

  // stage 2: t = full*D - s*(D - frac), numerator of the secondary term over v
  logic [TW-1:0] t_c;
  logic [DW-1:0] dist_c;

  always_comb begin
    dist_c = DW'(SEXT) - frac1;
    t_c = TW'(DEN) - TW'(TW'(saturation) * TW'(dist_c));
  end

  sextant_t              sx2;
  logic                  oor2;
  logic [TW-1:0]         t2;
  logic [COLOR_BITS-1:0] inv_sat2;

  always_ff @(posedge clk) begin
    if (adv) begin
      sx2 <= sx1;
      oor2 <= oor1;
      t2 <= t_c;
      inv_sat2 <= COLOR_BITS'(FULL) - saturation;
    end
  end

  // stage 3: scale by brightness, drop the power of two of the denominator
  logic [PW-1:0]           nmid_c;
  logic [2*COLOR_BITS-1:0] plow_c;
  logic [XW-1:0]           xlow_c;

  always_comb begin
    nmid_c = PW'(brightness) * PW'(t2);
    plow_c = (2 * COLOR_BITS)'(brightness) * (2 * COLOR_BITS)'(inv_sat2);
    // times 15 as 16x - x
    xlow_c = (XW'(plow_c) << 4) - XW'(plow_c);
  end

  sextant_t      sx3;
  logic          oor3;
  logic [XW-1:0] xmid3;
  logic [XW-1:0] xlow3;

  always_ff @(posedge clk) begin
    if (adv) begin
      sx3 <= sx2;
      oor3 <= oor2;
      xmid3 <= nmid_c[PW-1:SHIFT];
      xlow3 <= xlow_c;
    end
  end

  // stage 4: quotient estimate by reciprocal, low by at most one
  logic [XW+RW-1:0] pmid_c;
  logic [XW+RW-1:0] plow4_c;

  always_comb begin
    pmid_c = (XW + RW)'(xmid3) * (XW + RW)'(RECIP);
    plow4_c = (XW + RW)'(xlow3) * (XW + RW)'(RECIP);
  end

  sextant_t              sx4;
  logic                  oor4;
  logic [XW-1:0]         xmid4;
  logic [XW-1:0]         xlow4;
  logic [COLOR_BITS-1:0] qmid4;
  logic [COLOR_BITS-1:0] qlow4;

  always_ff @(posedge clk) begin
    if (adv) begin
      sx4 <= sx3;
      oor4 <= oor3;
      xmid4 <= xmid3;
      xlow4 <= xlow3;
      qmid4 <= COLOR_BITS'(pmid_c >> XW);
      qlow4 <= COLOR_BITS'(plow4_c >> XW);
    end
  end

  // stage 5: remainder check fixes the estimate, then channel steering
  logic [XW-1:0]         rmid_c;
  logic [XW-1:0]         rlow_c;
  logic [COLOR_BITS-1:0] mid_c;
  logic [COLOR_BITS-1:0] low_c;
  logic [COLOR_BITS-1:0] top_c;
  logic [COLOR_BITS-1:0] red_c;
  logic [COLOR_BITS-1:0] green_c;
  logic [COLOR_BITS-1:0] blue_c;

  always_comb begin
    rmid_c = xmid4 - XW'(XW'(qmid4) * XW'(KDIV));
    rlow_c = xlow4 - XW'(XW'(qlow4) * XW'(KDIV));
    mid_c = qmid4 + COLOR_BITS'(rmid_c >= XW'(KDIV));
    low_c = qlow4 + COLOR_BITS'(rlow_c >= XW'(KDIV));
    top_c = brightness;
    if (oor4) begin
      red_c = low_c;
      green_c = low_c;
      blue_c = low_c;
    end else begin
      case (sx4)
        SXT_RED_YELLOW: begin
          red_c = top_c; green_c = mid_c; blue_c = low_c;
        end
        SXT_YELLOW_GREEN: begin
          red_c = mid_c; green_c = top_c; blue_c = low_c;
        end
        SXT_GREEN_CYAN: begin
          red_c = low_c; green_c = top_c; blue_c = mid_c;
        end
        SXT_CYAN_BLUE: begin
          red_c = low_c; green_c = mid_c; blue_c = top_c;
        end
        SXT_BLUE_MAGENTA: begin
          red_c = mid_c; green_c = low_c; blue_c = top_c;
        end
        default: begin
          red_c = top_c; green_c = low_c; blue_c = mid_c;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (adv) begin
      pixel_out.red <= red_c;
      pixel_out.green <= green_c;
      pixel_out.blue <= blue_c;
      pixel_out.hue_out_of_range <= oor4;
    end
  end

endmodule

@@ tb/sv/hsv_to_rgb_pixel_tb.sv @@
module hsv_to_rgb_pixel_tb import h2r_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HUE_FRACTION_BITS = HUE_FRACTION_BITS_DEF;
  localparam int COLOR_BITS = COLOR_BITS_DEF;

  // color scale, sextant width and hue limit in hue lsbs
  localparam longint FULL_LEVEL = (longint'(1) << COLOR_BITS) - 1;
  localparam longint SEXTANT_W = longint'(60) << HUE_FRACTION_BITS;
  localparam longint HUE_LIMIT = 6 * SEXTANT_W;

  // pipeline is five deep; leave some slack before touching the registers
  localparam int DRAIN_CYCLES = 12;
  localparam int PHASE_COUNT = 10;
  localparam int ITEMS_PER_PHASE = 153;
  localparam longint TIMEOUT_NS = 4_000_000;

  typedef struct packed {
    logic [COLOR_BITS-1:0] red;
    logic [COLOR_BITS-1:0] green;
    logic [COLOR_BITS-1:0] blue;
    logic                  hue_out_of_range;
  } pixel_color_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [COLOR_BITS-1:0]  cfg_data;

  h2r_hue_if                               hue_ch ();
  h2r_rgb_if #(.COLOR_BITS(COLOR_BITS))    rgb_ch ();

  hsv_to_rgb_pixel #(
    .HUE_FRACTION_BITS(HUE_FRACTION_BITS),
    .COLOR_BITS(COLOR_BITS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .pixel_in(hue_ch),
    .pixel_out(rgb_ch)
  );

  // shadow copies of the two color registers
  logic [COLOR_BITS-1:0] saturation_reg;
  logic [COLOR_BITS-1:0] brightness_reg;

  // hues waiting to be sent, colors waiting to come back
  logic signed [HUE_WIDTH-1:0] pending_hues[$];
  pixel_color_t                expected_colors[$];

  // idle and stall odds in percent, changed per phase
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int          error_count;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // exact hsv to rgb for one hue under the current register values;
  // every channel is floored, so no rounding anywhere
  function automatic pixel_color_t predict_color(logic signed [HUE_WIDTH-1:0] hue);
    pixel_color_t c;
    longint h, v, s, low, mid, pos, frac, den;
    longint r, g, b;
    sextant_t sx;
    h = longint'(hue);
    v = longint'(brightness_reg);
    s = longint'(saturation_reg);
    // offset level m = v * (1 - s)
    low = v * (FULL_LEVEL - s) / FULL_LEVEL;
    if (h < 0 || h >= HUE_LIMIT) begin
      c.red = low[COLOR_BITS-1:0];
      c.green = low[COLOR_BITS-1:0];
      c.blue = low[COLOR_BITS-1:0];
      c.hue_out_of_range = 1'b1;
      return c;
    end
    sx = sextant_t'(h / SEXTANT_W);
    pos = h % SEXTANT_W;
    // odd sextants run the secondary term downward
    frac = sx[0] ? SEXTANT_W - pos : pos;
    den = FULL_LEVEL * SEXTANT_W;
    mid = (v * den - v * s * (SEXTANT_W - frac)) / den;
    case (sx)
      SXT_RED_YELLOW: begin
        r = v; g = mid; b = low;
      end
      SXT_YELLOW_GREEN: begin
        r = mid; g = v; b = low;
      end
      SXT_GREEN_CYAN: begin
        r = low; g = v; b = mid;
      end
      SXT_CYAN_BLUE: begin
        r = low; g = mid; b = v;
      end
      SXT_BLUE_MAGENTA: begin
        r = mid; g = low; b = v;
      end
      default: begin
        r = v; g = low; b = mid;
      end
    endcase
    c.red = r[COLOR_BITS-1:0];
    c.green = g[COLOR_BITS-1:0];
    c.blue = b[COLOR_BITS-1:0];
    c.hue_out_of_range = 1'b0;
    return c;
  endfunction

  // mostly in-range hues, some hugging sextant edges and the wrap points,
  // the rest anywhere in the 14-bit word
  function automatic logic signed [HUE_WIDTH-1:0] random_hue();
    int unsigned pick;
    longint h;
    pick = $urandom_range(99);
    if (pick < 75) begin
      h = longint'($urandom_range(32'(HUE_LIMIT - 1)));
    end else if (pick < 88) begin
      h = longint'($urandom_range(6)) * SEXTANT_W + longint'($urandom_range(6)) - 3;
    end else begin
      h = longint'($urandom);
    end
    return h[HUE_WIDTH-1:0];
  endfunction

  // driver: one hue word per transfer; prediction is taken at acceptance
  always @(posedge clk) begin
    if (rst) begin
      hue_ch.valid <= 1'b0;
      hue_ch.hue <= '0;
    end else begin
      if (hue_ch.valid && hue_ch.ready) begin
        expected_colors.push_back(predict_color(hue_ch.hue));
      end
      if (!hue_ch.valid || hue_ch.ready) begin
        if (pending_hues.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          hue_ch.valid <= 1'b1;
          hue_ch.hue <= pending_hues.pop_front();
        end else begin
          hue_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each color transfer against the oldest prediction
  always @(posedge clk) begin
    pixel_color_t want;
    if (rst) begin
      rgb_ch.ready <= 1'b0;
    end else begin
      if (rgb_ch.valid && rgb_ch.ready) begin
        if (expected_colors.size() == 0) begin
          $error("unexpected color transfer: red %0d green %0d blue %0d",
                 rgb_ch.red, rgb_ch.green, rgb_ch.blue);
          error_count++;
        end else begin
          want = expected_colors.pop_front();
          if (rgb_ch.red !== want.red) begin
            $error("red: expected %0d, got %0d", want.red, rgb_ch.red);
            error_count++;
          end
          if (rgb_ch.green !== want.green) begin
            $error("green: expected %0d, got %0d", want.green, rgb_ch.green);
            error_count++;
          end
          if (rgb_ch.blue !== want.blue) begin
            $error("blue: expected %0d, got %0d", want.blue, rgb_ch.blue);
            error_count++;
          end
          if (rgb_ch.hue_out_of_range !== want.hue_out_of_range) begin
            $error("hue_out_of_range: expected %0d, got %0d",
                   want.hue_out_of_range, rgb_ch.hue_out_of_range);
            error_count++;
          end
        end
      end
      rgb_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // block until every queued hue has gone in and every color came out
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_hues.size() != 0 || hue_ch.valid || expected_colors.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one register write, one cycle of write enable
  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [COLOR_BITS-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    if (idx == REG_SATURATION) begin
      saturation_reg = data;
    end else begin
      brightness_reg = data;
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // idling modes: none, sender idle, receiver stalling, both
  task automatic set_idling(input int mode);
    case (mode)
      0: begin
        send_idle_pct = 0; recv_stall_pct = 0;
      end
      1: begin
        send_idle_pct = 78; recv_stall_pct = 0;
      end
      2: begin
        send_idle_pct = 0; recv_stall_pct = 78;
      end
      default: begin
        send_idle_pct = 19; recv_stall_pct = 19;
      end
    endcase
  endtask

  // stimulus
  initial begin
    logic [COLOR_BITS-1:0] sat, bright;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    hue_ch.valid = 1'b0;
    hue_ch.hue = '0;
    rgb_ch.ready = 1'b0;
    error_count = 0;
    set_idling(0);
    // register values after reset: saturation 0.8, brightness full
    saturation_reg = COLOR_BITS'((FULL_LEVEL * 4 + 2) / 5);
    brightness_reg = COLOR_BITS'(FULL_LEVEL);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: wheel start and end, sextant edges, mid points, the first
    // hue past 360, negative hues and both ends of the 14-bit word
    pending_hues.push_back(HUE_WIDTH'(0));
    pending_hues.push_back(HUE_WIDTH'(1));
    pending_hues.push_back(HUE_WIDTH'(SEXTANT_W / 2));
    pending_hues.push_back(HUE_WIDTH'(SEXTANT_W - 1));
    pending_hues.push_back(HUE_WIDTH'(SEXTANT_W));
    pending_hues.push_back(HUE_WIDTH'(SEXTANT_W + 1));
    pending_hues.push_back(HUE_WIDTH'(2 * SEXTANT_W - 1));
    pending_hues.push_back(HUE_WIDTH'(2 * SEXTANT_W));
    pending_hues.push_back(HUE_WIDTH'(5 * SEXTANT_W / 2));
    pending_hues.push_back(HUE_WIDTH'(3 * SEXTANT_W));
    pending_hues.push_back(HUE_WIDTH'(4 * SEXTANT_W));
    pending_hues.push_back(HUE_WIDTH'(9 * SEXTANT_W / 2));
    pending_hues.push_back(HUE_WIDTH'(5 * SEXTANT_W));
    pending_hues.push_back(HUE_WIDTH'(HUE_LIMIT - 1));
    pending_hues.push_back(HUE_WIDTH'(HUE_LIMIT));
    pending_hues.push_back(HUE_WIDTH'(HUE_LIMIT + 1));
    pending_hues.push_back(HUE_WIDTH'(-1));
    pending_hues.push_back(HUE_WIDTH'(-8192));
    pending_hues.push_back(HUE_WIDTH'(8191));
    pending_hues.push_back(HUE_WIDTH'(-SEXTANT_W));
    wait_drained();

    // random phases: register extremes first, then random settings
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      case (ph)
        0: begin
          sat = COLOR_BITS'(FULL_LEVEL); bright = COLOR_BITS'(FULL_LEVEL);
        end
        1: begin
          sat = '0; bright = COLOR_BITS'(FULL_LEVEL);
        end
        2: begin
          sat = COLOR_BITS'(FULL_LEVEL); bright = '0;
        end
        3: begin
          sat = '0; bright = '0;
        end
        4: begin
          sat = COLOR_BITS'(1); bright = COLOR_BITS'(FULL_LEVEL - 1);
        end
        default: begin
          sat = COLOR_BITS'($urandom_range(32'(FULL_LEVEL)));
          bright = COLOR_BITS'($urandom_range(32'(FULL_LEVEL)));
        end
      endcase
      write_register(REG_SATURATION, sat);
      write_register(REG_BRIGHTNESS, bright);
      set_idling(ph % 4);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // sender holds off once mid-phase until the pipeline is empty
        if (ph == 6 && n == ITEMS_PER_PHASE / 2) begin
          wait_drained();
        end
        pending_hues.push_back(random_hue());
      end
      wait_drained();
    end

    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // hard stop well past the slowest legal run
  initial begin
    #(TIMEOUT_NS);
    $display("tb: failure");
    $finish;
  end

endmodule
